[src/rsapx_pkg.sv]
package rsapx_pkg;

   localparam int PRIME_W     = 31;
   localparam int PRIME_BITS  = 31;
   localparam int EXP_W       = 62;
   localparam int T_W         = 64;
   localparam int NUM_W       = 64;
   localparam int CNT_W       = $clog2(NUM_W);
   localparam int GUARD_LIMIT = 128;
   localparam int GUARD_W     = $clog2(GUARD_LIMIT) + 1;
   localparam int STATUS_W    = 2;
   localparam int REQ_W       = 128;
   localparam int RSP_W       = 64;

   localparam logic [PRIME_W-1:0] PRIME_MASK = PRIME_W'((64'd1 << PRIME_BITS) - 64'd1);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_NOT_COPRIME = 2'd1,
      ST_BAD_MODULUS = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PHI,
      OP_DIV_RED,
      OP_INIT,
      OP_DIV_STEP,
      OP_STEP,
      OP_DIV_MOD,
      OP_SET_OK,
      OP_SET_NC,
      OP_SET_BAD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic bad;
      logic div_busy;
      logic div_done;
      logic r_zero;
      logic r_one;
      logic guard_full;
   } sts_type;

endpackage

[src/rsapx_div.sv]
module rsapx_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rsapx_pkg::NUM_W-1:0] num,
   input  logic [rsapx_pkg::EXP_W-1:0] den,
   input  logic [rsapx_pkg::T_W-1:0]   mult,
   output logic [rsapx_pkg::EXP_W-1:0] rem,
   output logic [rsapx_pkg::T_W-1:0]   prod,
   output logic                       busy,
   output logic                       done
);
   import rsapx_pkg::*;

   logic [NUM_W-1:0] num_ff;
   logic [EXP_W-1:0] den_ff;
   logic [T_W-1:0]   mult_ff;
   logic [EXP_W-1:0] rem_ff, rem_in;
   logic [T_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [EXP_W:0]   trial;
   logic [EXP_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = ge ? diff[EXP_W-1:0] : trial[EXP_W-1:0];
      prod_in = {prod_ff[T_W-2:0], 1'b0} + (ge ? mult_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         mult_ff <= mult;
         rem_ff  <= '0;
         prod_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff  <= rem_in;
         prod_ff <= prod_in;
      end
   end

   assign rem  = rem_ff;
   assign prod = prod_ff;
   assign busy = busy_ff;
   assign done = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a finished run");

endmodule

[src/rsapx_dp.sv]
module rsapx_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rsapx_pkg::op_type             op,
   input  logic [rsapx_pkg::PRIME_W-1:0] prime_p,
   input  logic [rsapx_pkg::PRIME_W-1:0] prime_q,
   input  logic [rsapx_pkg::EXP_W-1:0]   pub_exp,
   output rsapx_pkg::sts_type            sts,
   output logic [rsapx_pkg::EXP_W-1:0]   priv_exp,
   output rsapx_pkg::status_type         status
);
   import rsapx_pkg::*;

   logic [PRIME_W-1:0]   p_ff, q_ff;
   logic [EXP_W-1:0]     e_ff, phi_ff, r_prev_ff, r_cur_ff;
   logic [T_W-1:0]       t_prev_ff, t_cur_ff;
   logic [GUARD_W-1:0]   guard_ff;
   logic [EXP_W-1:0]     res_d_ff, priv_exp_ff;
   status_type           res_st_ff, status_ff;
   logic [PRIME_W-1:0]   pm1, qm1;
   logic [2*PRIME_W-1:0] phi_in;
   logic                 div_start;
   logic [NUM_W-1:0]     div_num;
   logic [EXP_W-1:0]     div_den;
   logic [T_W-1:0]       div_mult;
   logic [EXP_W-1:0]     div_rem;
   logic [T_W-1:0]       div_prod;
   logic                 div_busy, div_done;
   logic [EXP_W-1:0]     d_ok;

   always_comb begin
      pm1    = p_ff - 1'b1;
      qm1    = q_ff - 1'b1;
      phi_in = pm1 * qm1;
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = NUM_W'(e_ff);
      div_den   = phi_ff;
      div_mult  = '0;
      case (op)
         OP_DIV_RED: begin
            div_start = 1'b1;
         end
         OP_DIV_STEP: begin
            div_start = 1'b1;
            div_num   = NUM_W'(r_prev_ff);
            div_den   = r_cur_ff;
            div_mult  = t_cur_ff;
         end
         OP_DIV_MOD: begin
            div_start = 1'b1;
            div_num   = t_prev_ff[T_W-1] ? (T_W'(0) - t_prev_ff) : t_prev_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   rsapx_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .mult  (div_mult),
      .rem   (div_rem),
      .prod  (div_prod),
      .busy  (div_busy),
      .done  (div_done)
   );

   always_comb begin
      if (!t_prev_ff[T_W-1]) begin
         d_ok = div_rem;
      end else if (div_rem == '0) begin
         d_ok = '0;
      end else begin
         d_ok = phi_ff - div_rem;
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            p_ff <= prime_p & PRIME_MASK;
            q_ff <= prime_q & PRIME_MASK;
            e_ff <= pub_exp;
         end
         OP_PHI: begin
            phi_ff <= EXP_W'(phi_in);
         end
         OP_INIT: begin
            r_prev_ff <= phi_ff;
            r_cur_ff  <= div_rem;
            t_prev_ff <= '0;
            t_cur_ff  <= T_W'(1);
            guard_ff  <= '0;
         end
         OP_STEP: begin
            r_prev_ff <= r_cur_ff;
            r_cur_ff  <= div_rem;
            t_prev_ff <= t_cur_ff;
            t_cur_ff  <= t_prev_ff - div_prod;
            guard_ff  <= guard_ff + 1'b1;
         end
         OP_SET_OK: begin
            res_d_ff  <= d_ok;
            res_st_ff <= ST_OK;
         end
         OP_SET_NC: begin
            res_d_ff  <= '0;
            res_st_ff <= ST_NOT_COPRIME;
         end
         OP_SET_BAD: begin
            res_d_ff  <= '0;
            res_st_ff <= ST_BAD_MODULUS;
         end
         OP_EMIT: begin
            priv_exp_ff <= res_d_ff;
            status_ff   <= res_st_ff;
         end
         default: begin
            guard_ff <= guard_ff;
         end
      endcase
   end

   always_comb begin
      sts.bad        = (p_ff[PRIME_W-1:1] == '0) || (q_ff[PRIME_W-1:1] == '0);
      sts.div_busy   = div_busy;
      sts.div_done   = div_done;
      sts.r_zero     = r_cur_ff == '0;
      sts.r_one      = r_prev_ff == EXP_W'(1);
      sts.guard_full = guard_ff == GUARD_W'(GUARD_LIMIT);
   end

   assign priv_exp = priv_exp_ff;
   assign status   = status_ff;

   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      (op == OP_STEP) |=> (guard_ff == $past(guard_ff) + 1'b1))
      else $error("step count did not advance");

endmodule

[src/rsapx_ctrl.sv]
module rsapx_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  rsapx_pkg::sts_type sts,
   output rsapx_pkg::op_type  op
);
   import rsapx_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PHI,
      S_CHECK,
      S_RED,
      S_LOOP,
      S_STEP,
      S_MOD,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op           = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = S_PHI;
            end
         end
         S_PHI: begin
            op       = OP_PHI;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.bad) begin
               op       = OP_SET_BAD;
               state_in = S_EMIT;
            end else begin
               op       = OP_DIV_RED;
               state_in = S_RED;
            end
         end
         S_RED: begin
            if (sts.div_done) begin
               op       = OP_INIT;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (!sts.r_zero && !sts.guard_full) begin
               op       = OP_DIV_STEP;
               state_in = S_STEP;
            end else if (!sts.r_one) begin
               op       = OP_SET_NC;
               state_in = S_EMIT;
            end else begin
               op       = OP_DIV_MOD;
               state_in = S_MOD;
            end
         end
         S_STEP: begin
            if (sts.div_done) begin
               op       = OP_STEP;
               state_in = S_LOOP;
            end
         end
         S_MOD: begin
            if (sts.div_done) begin
               op       = OP_SET_OK;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               op           = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_DIV_RED || op == OP_DIV_STEP || op == OP_DIV_MOD) |-> !sts.div_busy)
      else $error("divider started while busy");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_EMIT) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_wait_on_divider: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_STEP || state_ff == S_MOD || state_ff == S_RED) && !sts.div_done)
      |-> sts.div_busy)
      else $error("waiting on an idle divider");

endmodule

[src/rsa_private_exponent.sv]
// The number of Euclid steps is bounded at 128 by a guard counter; a bad modulus skips
// the divider and goes straight to the result.
// Each Euclid step, the first reduction and the final reduction run one pass of the shared
// restoring divider, which also accumulates the quotient times the coefficient.
// Throughput: one transaction at a time; the next is accepted while a result waits.
// Reset: synchronous, active high; clears the controller and the divider, drops rsp_tvalid.
module rsa_private_exponent (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [30:0] prime_p, [61:31] prime_q, [123:62] pub_exp, [127:124] zero
   input  logic [rsapx_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [61:0] priv_exp, [63:62] zero
   output logic [rsapx_pkg::RSP_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [rsapx_pkg::STATUS_W-1:0] rsp_tuser
);
   import rsapx_pkg::*;

   op_type             op;
   sts_type            sts;
   logic [EXP_W-1:0]   priv_exp;
   status_type         status;
   logic [PRIME_W-1:0] prime_p, prime_q;
   logic [EXP_W-1:0]   pub_exp;

   assign prime_p = req_tdata[PRIME_W-1:0];
   assign prime_q = req_tdata[2*PRIME_W-1:PRIME_W];
   assign pub_exp = req_tdata[2*PRIME_W+EXP_W-1:2*PRIME_W];

   rsapx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .op         (op)
   );

   rsapx_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .prime_p  (prime_p),
      .prime_q  (prime_q),
      .pub_exp  (pub_exp),
      .sts      (sts),
      .priv_exp (priv_exp),
      .status   (status)
   );

   assign rsp_tdata = {{(RSP_W-EXP_W){1'b0}}, priv_exp};
   assign rsp_tuser = status;

endmodule
